/* src/c39d_pkg.sv */
// Shared types, constants and the letter lookup for the Code 39 letter decoder.
package c39d_pkg;

    localparam int RUN_TOTAL    = 29;
    localparam int ADDR_BITS    = $clog2(RUN_TOTAL);
    localparam int GROUP_LEN    = 9;
    localparam int GROUP_STRIDE = 10;
    localparam int SLOT_COUNT   = GROUP_STRIDE;
    localparam int SLOT_BITS    = $clog2(SLOT_COUNT + 1);
    localparam int RANK_BITS    = $clog2(GROUP_LEN + 1);
    localparam int RANK_NARROW  = GROUP_LEN - 4;
    localparam int RANK_WIDE    = GROUP_LEN - 3;
    localparam int WIDE_ELEMS   = 3;
    localparam int RATIO_NUM    = 18;
    localparam int RATIO_DEN    = 10;
    localparam int LETTER_COUNT = 26;
    localparam int LETTER_BITS  = 5;
    localparam int RUN_IN_BITS  = 16;

    typedef logic [GROUP_LEN-1:0]   t_pat;
    typedef logic [ADDR_BITS-1:0]   t_addr;
    typedef logic [SLOT_BITS-1:0]   t_slot;
    typedef logic [LETTER_BITS-1:0] t_letter;
    typedef logic [1:0]             t_grp;

    localparam t_grp GRP_START  = 2'd0;
    localparam t_grp GRP_LETTER = 2'd1;
    localparam t_grp GRP_STOP   = 2'd2;

    localparam t_pat ASTERISK = 9'h094;

    localparam t_pat LETTER_TABLE [LETTER_COUNT] = '{
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D,
        9'h10C, 9'h04C, 9'h01C, 9'h103, 9'h043, 9'h142, 9'h013,
        9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016, 9'h181,
        9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0
    };

    typedef struct packed {
        logic    hit;
        t_letter idx;
    } t_lookup;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        logic  rd_en;
        t_addr rd_addr;
        logic  ld_en;
        t_slot ld_slot;
        logic  rank_en;
        t_slot rank_idx;
        logic  eval_en;
        t_grp  grp;
        logic  post;
        logic  post_ok;
        logic  dir;
    } t_cmd;

    typedef struct packed {
        logic grp_ok;
    } t_sts;

    function automatic t_lookup letter_lookup(input t_pat pat);
        t_lookup res;
        res = '0;
        for (int k = 0; k < LETTER_COUNT; k++) begin
            if (!res.hit && LETTER_TABLE[k] == pat) begin
                res.hit = 1'b1;
                res.idx = LETTER_BITS'(k);
            end
        end
        return res;
    endfunction

endpackage

/* src/c39d_if.sv */
// Request channel interfaces: run input and decode result.
interface c39d_run_if;
    logic                               valid;
    logic                               ready;
    logic [c39d_pkg::RUN_IN_BITS-1:0]   run_width;
    logic                               scan_start;

    modport source (output valid, run_width, scan_start, input ready);
    modport sink   (input valid, run_width, scan_start, output ready);
endinterface

interface c39d_res_if;
    logic                 valid;
    logic                 ready;
    logic                 decoded;
    c39d_pkg::t_letter    letter_index;
    logic                 reversed;

    modport source (output valid, decoded, letter_index, reversed, input ready);
    modport sink   (input valid, decoded, letter_index, reversed, output ready);
endinterface

/* src/c39d_ctrl.sv */
// Sequencer: run counting, decode pass control and result handshake.
module c39d_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_scan_start,
    input  logic            i_out_ready,
    input  c39d_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output c39d_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_RANK = 5'b00100,
        S_EVAL = 5'b01000,
        S_POST = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    c39d_pkg::t_addr r_cnt, n_cnt;
    logic            r_dir, n_dir;
    c39d_pkg::t_grp  r_grp, n_grp;
    c39d_pkg::t_slot r_elem, n_elem;
    c39d_pkg::t_slot r_idx, n_idx;
    logic            r_ok, n_ok;
    logic            r_out_valid, n_out_valid;

    logic            accept;
    logic            post;
    c39d_pkg::t_addr cnt_eff;
    c39d_pkg::t_slot load_last;
    c39d_pkg::t_addr base;
    c39d_pkg::t_addr fwd_addr;

    always_comb begin
        accept    = i_in_valid && (r_state == S_IDLE);
        post      = (r_state == S_POST) && (!r_out_valid || i_out_ready);
        cnt_eff   = i_scan_start ? '0 : r_cnt;
        load_last = (r_grp == c39d_pkg::GRP_STOP) ? c39d_pkg::SLOT_BITS'(c39d_pkg::GROUP_LEN)
                                                  : c39d_pkg::SLOT_BITS'(c39d_pkg::GROUP_STRIDE);
        case (r_grp)
            c39d_pkg::GRP_START:  base = '0;
            c39d_pkg::GRP_LETTER: base = c39d_pkg::ADDR_BITS'(c39d_pkg::GROUP_STRIDE);
            c39d_pkg::GRP_STOP:   base = c39d_pkg::ADDR_BITS'(2 * c39d_pkg::GROUP_STRIDE);
            default:              base = '0;
        endcase
        fwd_addr = base + c39d_pkg::ADDR_BITS'(r_elem);

        o_cmd          = '0;
        o_cmd.wr_en    = accept;
        o_cmd.wr_addr  = cnt_eff;
        o_cmd.rd_en    = (r_state == S_LOAD) && (r_elem < load_last);
        o_cmd.rd_addr  = r_dir ? c39d_pkg::ADDR_BITS'(c39d_pkg::RUN_TOTAL - 1) - fwd_addr
                               : fwd_addr;
        o_cmd.ld_en    = (r_state == S_LOAD) && (r_elem != '0);
        o_cmd.ld_slot  = r_elem - 1'b1;
        o_cmd.rank_en  = (r_state == S_RANK);
        o_cmd.rank_idx = r_idx;
        o_cmd.eval_en  = (r_state == S_EVAL);
        o_cmd.grp      = r_grp;
        o_cmd.post     = post;
        o_cmd.post_ok  = r_ok;
        o_cmd.dir      = r_dir;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dir       = r_dir;
        n_grp       = r_grp;
        n_elem      = r_elem;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (cnt_eff == c39d_pkg::ADDR_BITS'(c39d_pkg::RUN_TOTAL - 1)) begin
                        n_cnt   = '0;
                        n_dir   = 1'b0;
                        n_grp   = c39d_pkg::GRP_START;
                        n_elem  = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_cnt = cnt_eff + 1'b1;
                    end
                end
            end
            S_LOAD: begin
                if (r_elem == load_last) begin
                    n_idx   = '0;
                    n_state = S_RANK;
                end else begin
                    n_elem = r_elem + 1'b1;
                end
            end
            S_RANK: begin
                if (r_idx == c39d_pkg::SLOT_BITS'(c39d_pkg::GROUP_LEN - 1)) begin
                    n_state = S_EVAL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EVAL: begin
                if (i_sts.grp_ok) begin
                    if (r_grp == c39d_pkg::GRP_STOP) begin
                        n_ok    = 1'b1;
                        n_state = S_POST;
                    end else begin
                        n_grp   = r_grp + 1'b1;
                        n_elem  = '0;
                        n_state = S_LOAD;
                    end
                end else if (!r_dir) begin
                    n_dir   = 1'b1;
                    n_grp   = c39d_pkg::GRP_START;
                    n_elem  = '0;
                    n_state = S_LOAD;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (post) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_dir       <= 1'b0;
            r_grp       <= c39d_pkg::GRP_START;
            r_elem      <= '0;
            r_idx       <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dir       <= n_dir;
            r_grp       <= n_grp;
            r_elem      <= n_elem;
            r_idx       <= n_idx;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* src/c39d_dp.sv */
// Datapath: run memory, group registers, rank unit and group checks.
module c39d_dp #(
    parameter int WIDTH_BITS = 16
) (
    input  logic                                i_clk,
    input  logic [c39d_pkg::RUN_IN_BITS-1:0]    i_run_width,
    input  c39d_pkg::t_cmd                      i_cmd,
    output c39d_pkg::t_sts                      o_sts,
    output logic                                o_decoded,
    output c39d_pkg::t_letter                   o_letter_index,
    output logic                                o_reversed
);

    localparam int MW = WIDTH_BITS + 5;

    logic [WIDTH_BITS-1:0] r_mem [c39d_pkg::RUN_TOTAL];
    logic [WIDTH_BITS-1:0] r_rd;
    logic [WIDTH_BITS-1:0] r_slot [c39d_pkg::SLOT_COUNT];
    logic [WIDTH_BITS-1:0] r_narrow;
    logic [WIDTH_BITS-1:0] r_wide;
    c39d_pkg::t_letter     r_letter;
    logic                  r_decoded;
    c39d_pkg::t_letter     r_letter_out;
    logic                  r_reversed;

    logic [WIDTH_BITS-1:0]          sel;
    logic [c39d_pkg::RANK_BITS-1:0] rank;
    logic                           any_zero;
    logic                           ratio_fail;
    logic [WIDTH_BITS-1:0]          thr;
    c39d_pkg::t_pat                 pat;
    logic [c39d_pkg::RANK_BITS-1:0] wide_cnt;
    logic                           gap_ok;
    logic                           pat_ok;
    c39d_pkg::t_lookup              look;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= WIDTH_BITS'(i_run_width);
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
    end

    // Rank of one element with ties broken by position.
    always_comb begin
        sel  = r_slot[i_cmd.rank_idx];
        rank = '0;
        for (int j = 0; j < c39d_pkg::GROUP_LEN; j++) begin
            if (r_slot[j] < sel ||
                (r_slot[j] == sel && c39d_pkg::SLOT_BITS'(j) < i_cmd.rank_idx)) begin
                rank = rank + 1'b1;
            end
        end
    end

    always_comb begin
        any_zero   = 1'b0;
        wide_cnt   = '0;
        ratio_fail = (MW'(r_wide) * MW'(c39d_pkg::RATIO_DEN))
                   < (MW'(r_narrow) * MW'(c39d_pkg::RATIO_NUM));
        thr        = r_narrow + ((r_wide - r_narrow) >> 1);
        for (int i = 0; i < c39d_pkg::GROUP_LEN; i++) begin
            if (r_slot[i] == '0) begin
                any_zero = 1'b1;
            end
            pat[c39d_pkg::GROUP_LEN-1-i] = (r_slot[i] >= thr);
            if (r_slot[i] >= thr) begin
                wide_cnt = wide_cnt + 1'b1;
            end
        end
        look   = c39d_pkg::letter_lookup(pat);
        gap_ok = (i_cmd.grp == c39d_pkg::GRP_STOP) ||
                 (r_slot[c39d_pkg::SLOT_COUNT-1] < thr);
        pat_ok = (i_cmd.grp == c39d_pkg::GRP_LETTER) ? look.hit : (pat == c39d_pkg::ASTERISK);
        o_sts.grp_ok = !any_zero && !ratio_fail && gap_ok && pat_ok &&
                       (wide_cnt == c39d_pkg::RANK_BITS'(c39d_pkg::WIDE_ELEMS));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_en) begin
            r_slot[i_cmd.ld_slot] <= r_rd;
        end
        if (i_cmd.rank_en) begin
            if (rank == c39d_pkg::RANK_BITS'(c39d_pkg::RANK_NARROW)) begin
                r_narrow <= sel;
            end
            if (rank == c39d_pkg::RANK_BITS'(c39d_pkg::RANK_WIDE)) begin
                r_wide <= sel;
            end
        end
        if (i_cmd.eval_en && i_cmd.grp == c39d_pkg::GRP_LETTER) begin
            r_letter <= look.idx;
        end
        if (i_cmd.post) begin
            r_decoded    <= i_cmd.post_ok;
            r_letter_out <= i_cmd.post_ok ? r_letter : '0;
            r_reversed   <= i_cmd.post_ok && i_cmd.dir;
        end
    end

    assign o_decoded      = r_decoded;
    assign o_letter_index = r_letter_out;
    assign o_reversed     = r_reversed;

endmodule

/* src/code39_single_letter_decoder.sv */
// Top level of the Code 39 single-letter decoder.
// Accepts one bar or space run width per request and stores it; scan_start
// restarts the count so that run becomes element 0. A run that does not
// complete a scan of 29 yields nothing. The 29th run starts a decode pass:
// for each of the three groups (start, letter, stop) the sequencer reads 10
// runs (9 for the stop group) from the single-port run memory, one per cycle,
// ranks the 9 widths one element per cycle to find the largest narrow and
// smallest wide width, then checks the group. If the forward attempt fails,
// a reversed retry follows; one result is posted, after any wait for an
// earlier result to leave the output register. The input is held off during
// the pass; a posted result waits in the output register while new runs are
// taken. A failed decode reports decoded = 0 with letter and direction zero.
// Widths are stored at WIDTH_BITS.
module code39_single_letter_decoder #(
    parameter int WIDTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c39d_run_if.sink    i_run,
    c39d_res_if.source  o_res
);

    c39d_pkg::t_cmd w_cmd;
    c39d_pkg::t_sts w_sts;
    logic           w_in_ready;
    logic           w_out_valid;

    // Sequencer: counts runs, steps the group passes, owns the handshakes.
    c39d_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_run.valid),
        .i_scan_start (i_run.scan_start),
        .i_out_ready  (o_res.ready),
        .i_sts        (w_sts),
        .o_in_ready   (w_in_ready),
        .o_out_valid  (w_out_valid),
        .o_cmd        (w_cmd)
    );

    // Datapath: run memory, rank unit, checks and result payload.
    c39d_dp #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_run_width    (i_run.run_width),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_decoded      (o_res.decoded),
        .o_letter_index (o_res.letter_index),
        .o_reversed     (o_res.reversed)
    );

    assign i_run.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

    // A failed decode carries no letter and no direction.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.decoded) |->
            (o_res.letter_index == '0 && !o_res.reversed))
        else $error("failed decode carries a letter or direction");

    // Only A to Z can come out.
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.letter_index < c39d_pkg::LETTER_BITS'(c39d_pkg::LETTER_COUNT)))
        else $error("letter index out of range");

    // A new result follows a decode pass, during which the input was held off.
    a_post_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(!i_run.ready))
        else $error("result posted without a decode pass");

endmodule

/* test/tb_c39d_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the Code 39 letter decoder: predicts each scan's letter and checks results.
module tb_c39d_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c39d_run_if        run_ch,
    c39d_res_if        res_ch,
    output int         o_fail_count,
    output int         o_pending
);
    import c39d_pkg::*;

    typedef struct packed {
        logic    decoded;
        t_letter letter_index;
        logic    reversed;
    } t_scan_result;

    logic [15:0]  scan_runs [RUN_TOTAL];
    int           runs_held;
    t_scan_result letter_queue [$];
    int           fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = letter_queue.size();

    // Classify one group of nine widths; returns 0 when the group is rejected.
    function automatic bit classify_group(input logic [15:0] w [GROUP_LEN],
                                          output t_pat pat, output int thr);
        int srt [GROUP_LEN];
        int narrow, wide, tmp, wides;
        pat = '0;
        thr = 0;
        wides = 0;
        for (int i = 0; i < GROUP_LEN; i++) begin
            if (w[i] == 0) return 0;
            srt[i] = w[i];
        end
        for (int i = 1; i < GROUP_LEN; i++)
            for (int j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
                tmp = srt[j]; srt[j] = srt[j-1]; srt[j-1] = tmp;
            end
        narrow = srt[GROUP_LEN - WIDE_ELEMS - 1];
        wide   = srt[GROUP_LEN - WIDE_ELEMS];
        if (longint'(wide) * RATIO_DEN < longint'(narrow) * RATIO_NUM) return 0;
        thr = narrow + (wide - narrow) / 2;
        for (int i = 0; i < GROUP_LEN; i++) begin
            pat = {pat[GROUP_LEN-2:0], (w[i] >= thr)};
            if (w[i] >= thr) wides++;
        end
        return wides == WIDE_ELEMS;
    endfunction

    function automatic bit decode_dir(input bit rev, output t_letter letter);
        logic [15:0] w [GROUP_LEN];
        t_pat pats [3];
        int   thrs [3];
        int   idx, gap0, gap1;
        letter = '0;
        for (int g = 0; g < 3; g++) begin
            for (int e = 0; e < GROUP_LEN; e++) begin
                idx = g * GROUP_STRIDE + e;
                w[e] = rev ? scan_runs[RUN_TOTAL-1-idx] : scan_runs[idx];
            end
            if (!classify_group(w, pats[g], thrs[g])) return 0;
        end
        if (pats[0] != ASTERISK || pats[2] != ASTERISK) return 0;
        gap0 = rev ? scan_runs[19] : scan_runs[9];
        gap1 = rev ? scan_runs[9] : scan_runs[19];
        if (gap0 >= thrs[0] || gap1 >= thrs[1]) return 0;
        for (int k = 0; k < LETTER_COUNT; k++)
            if (LETTER_TABLE[k] == pats[1]) begin
                letter = LETTER_BITS'(k);
                return 1;
            end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result want, got;
        t_letter      lt;
        if (!i_rst_n) begin
            runs_held  <= 0;
            fail_count <= 0;
            letter_queue.delete();
        end else begin
            if (run_ch.valid && run_ch.ready) begin
                int n;
                n = run_ch.scan_start ? 0 : runs_held;
                if (n >= RUN_TOTAL) n = 0;
                scan_runs[n] = run_ch.run_width;
                n++;
                if (n == RUN_TOTAL) begin
                    want = '0;
                    if (decode_dir(0, lt)) want = '{1'b1, lt, 1'b0};
                    else if (decode_dir(1, lt)) want = '{1'b1, lt, 1'b1};
                    letter_queue.push_back(want);
                    n = 0;
                end
                runs_held <= n;
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.decoded, res_ch.letter_index, res_ch.reversed};
                if (letter_queue.size() == 0) begin
                    $error("unexpected result decoded=%0d letter=%0d reversed=%0d",
                           got.decoded, got.letter_index, got.reversed);
                    fail_count <= fail_count + 1;
                end else begin
                    want = letter_queue.pop_front();
                    if (got != want) fail_count <= fail_count + 1;
                    if (got.decoded != want.decoded)
                        $error("decoded: expected %0d, got %0d", want.decoded, got.decoded);
                    if (got.letter_index != want.letter_index)
                        $error("letter_index: expected %0d, got %0d",
                               want.letter_index, got.letter_index);
                    if (got.reversed != want.reversed)
                        $error("reversed: expected %0d, got %0d", want.reversed, got.reversed);
                end
            end
        end
    end
endmodule

/* test/tb_code39_single_letter_decoder.sv */
`timescale 1ns / 1ps
// Testbench top: drives run scans into the Code 39 decoder and reports the verdict.
module tb_code39_single_letter_decoder;
    import c39d_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, cycle_count;
    bit   long_hold;      // receiver held off for a long stretch
    bit   stall_enable;   // allow random receiver stalls

    c39d_run_if run_ch ();
    c39d_res_if res_ch ();

    code39_single_letter_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run_ch.sink),
        .o_res   (res_ch.source)
    );

    tb_c39d_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .run_ch       (run_ch),
        .res_ch       (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: stall on its own pattern; hold ready low during a long hold-off.
    initial begin
        int phase;
        res_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (long_hold)
                res_ch.ready <= 1'b0;
            else if (!stall_enable)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ((phase % 7) < 4) ? ($urandom_range(0, 3) != 0)
                                                  : ($urandom_range(0, 1) != 0);
        end
    end

    // Scan content to be sent; filled by the build tasks below.
    logic [15:0] scan_buf [RUN_TOTAL];

    // Offer one request; hold it until accepted, with a given gap first.
    task automatic send_run(input logic [15:0] width, input logic start, input int gap);
        run_ch.valid = 1'b0;
        repeat (gap) @(negedge i_clk);
        run_ch.valid      = 1'b1;
        run_ch.run_width  = width;
        run_ch.scan_start = start;
        do @(posedge i_clk); while (!run_ch.ready);
        @(negedge i_clk);
        run_ch.valid = 1'b0;
    endtask

    // Send a run stream in bursts: no gap inside a burst, random gap between.
    int burst_left;
    task automatic send_paced(input logic [15:0] width, input logic start);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap == 0) begin
            // keep valid high straight into the next request
            run_ch.valid      = 1'b1;
            run_ch.run_width  = width;
            run_ch.scan_start = start;
            do @(posedge i_clk); while (!run_ch.ready);
            @(negedge i_clk);
            run_ch.valid = 1'b0;
        end else begin
            send_run(width, start, gap);
        end
    endtask

    // Encode one nine-element pattern with narrow n and wide w widths.
    task automatic put_group(input int base, input t_pat pat, input int n, input int w,
                             input bit jitter, input bit rev);
        int v;
        for (int e = 0; e < GROUP_LEN; e++) begin
            v = pat[GROUP_LEN-1-e] ? w : n;
            if (jitter) v = v + $urandom_range(0, v / 8 + 1) - (v / 16);
            if (v < 1) v = 1;
            if (v > 65535) v = 65535;
            if (rev) scan_buf[RUN_TOTAL-1-(base+e)] = 16'(v);
            else scan_buf[base+e] = 16'(v);
        end
    endtask

    // Build a well-formed scan of one letter, optionally reversed, with a narrow scale.
    task automatic build_scan(input int letter, input bit rev, input int n,
                              input int w, input bit jitter);
        put_group(0,  ASTERISK, n, w, jitter, rev);
        put_group(10, LETTER_TABLE[letter], n, w, jitter, rev);
        put_group(20, ASTERISK, n, w, jitter, rev);
        scan_buf[9]  = 16'(n);
        scan_buf[19] = 16'(n);
    endtask

    task automatic send_scan(input bit paced);
        for (int i = 0; i < RUN_TOTAL; i++)
            if (paced) send_paced(scan_buf[i], i == 0);
            else send_run(scan_buf[i], i == 0, 0);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    int items_sent, kind, nw;

    initial begin
        i_rst_n           = 1'b0;
        run_ch.valid      = 1'b0;
        run_ch.run_width  = '0;
        run_ch.scan_start = 1'b0;
        long_hold         = 1'b0;
        stall_enable      = 1'b0;
        burst_left        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: forward and reversed letters, and extreme widths.
        build_scan(0, 0, 1, 3, 0);          send_scan(0);   // A, narrowest
        build_scan(25, 1, 1, 3, 0);         send_scan(0);   // Z reversed
        build_scan(12, 0, 36000, 65535, 0); send_scan(0);   // saturated wide
        build_scan(7, 0, 10, 17, 0);        send_scan(0);   // ratio just under 1.8
        build_scan(7, 0, 10, 18, 0);        send_scan(0);   // ratio exactly 1.8
        build_scan(3, 0, 5, 15, 0); scan_buf[14] = 0; send_scan(0); // zero width
        build_scan(3, 0, 5, 15, 0); scan_buf[9] = 15; send_scan(0); // wide separator
        // Letter group holds the asterisk: not a letter.
        build_scan(0, 0, 5, 15, 0); put_group(10, ASTERISK, 5, 15, 0, 0); send_scan(0);
        // Incomplete scan restarted by scan_start, then a full scan.
        for (int i = 0; i < 10; i++) send_run(16'hFFFF, i == 0, 0);
        build_scan(19, 0, 4, 12, 0); send_scan(0);
        // A scan without scan_start follows the completed one.
        build_scan(21, 1, 6, 20, 0);
        for (int i = 0; i < RUN_TOTAL; i++) send_run(scan_buf[i], 1'b0, 0);
        wait_drained();
        items_sent = 10 * RUN_TOTAL + 10;

        // Back-pressure: hold the receiver while scans keep coming.
        stall_enable = 1'b1;
        long_hold = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                long_hold = 1'b0;
            end
            for (int s = 0; s < 4; s++) begin
                build_scan($urandom_range(0, 25), $urandom_range(0, 1), 3, 9, 1);
                send_scan(1);
            end
        join
        wait_drained();
        items_sent += 4 * RUN_TOTAL;

        // Random: mostly well-formed scans, some broken, some noise.
        while (items_sent < 1950) begin
            kind = $urandom_range(0, 9);
            nw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30000)
                                             : $urandom_range(1, 200);
            build_scan($urandom_range(0, 25), $urandom_range(0, 1), nw,
                       nw * 2 + $urandom_range(0, nw * 2), 1);
            if (kind == 7) scan_buf[$urandom_range(0, 28)] = 16'($urandom);
            if (kind == 8)
                for (int i = 0; i < RUN_TOTAL; i++) scan_buf[i] = 16'($urandom);
            if (kind == 9) scan_buf[$urandom_range(0, 28)] = 0;
            if ($urandom_range(0, 15) == 0) begin
                // abandoned partial scan
                for (int i = 0; i < $urandom_range(1, 28); i++) begin
                    send_paced(16'($urandom), i == 0);
                    items_sent++;
                end
            end
            send_scan(1);
            items_sent += RUN_TOTAL;
            if ($urandom_range(0, 20) == 0) begin
                stall_enable = ~stall_enable;
                wait_drained();
            end
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
